// File: rtl/lmrs_pkg.sv
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types, constants, font and preset tables of the LED matrix row
// scanner.
// ----------------------------------------------------------------------------
package lmrs_pkg;

    localparam int unsigned ROWS          = 7;
    localparam int unsigned COLUMNS       = 15;
    localparam int unsigned PHASES        = 2 * ROWS;
    localparam int unsigned PRESET_COUNT  = 13;
    localparam int unsigned GLYPH_COUNT   = 94;
    localparam int unsigned GLYPH_COLS    = 5;
    localparam int unsigned CHAR_SLOTS    = 3;

    localparam int unsigned ROW_W   = ROWS;
    localparam int unsigned COL_W   = COLUMNS;
    localparam int unsigned PHASE_W = $clog2(PHASES);
    localparam int unsigned RIDX_W  = $clog2(ROWS);
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned DUTY_W  = 14;
    localparam int unsigned PICK_W  = $clog2(PRESET_COUNT);
    localparam int unsigned TIME_W  = 32;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;
    localparam logic [7:0]        CHAR_LOW   = 8'd32;
    localparam logic [7:0]        CHAR_HIGH  = 8'd125;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 14'd10000;

    localparam logic [DUTY_W-1:0] BRIGHTNESS_RESET    = 14'd5000;
    localparam logic [3:0]        BLINK_PATTERN_RESET = 4'd12;

    // blink half period; parity of elapsed/period via reciprocal multiply
    localparam int unsigned BLINK_PERIOD_MS = 300;
    localparam int unsigned DIV_SHIFT       = TIME_W + $clog2(BLINK_PERIOD_MS);
    localparam logic [63:0] DIV_MULT_FULL   =
        ((64'd1 << DIV_SHIFT) / 64'(BLINK_PERIOD_MS)) + 64'd1;
    localparam int unsigned MULT_W      = 34;
    localparam int unsigned MULT_HALF_W = MULT_W / 2;
    localparam int unsigned PROD_HALF_W = TIME_W + MULT_HALF_W;
    localparam int unsigned PROD_W      = TIME_W + MULT_W;
    localparam logic [MULT_W-1:0]      DIV_MULT    = DIV_MULT_FULL[MULT_W-1:0];
    localparam logic [MULT_HALF_W-1:0] DIV_MULT_LO = DIV_MULT[MULT_HALF_W-1:0];
    localparam logic [MULT_HALF_W-1:0] DIV_MULT_HI = DIV_MULT[MULT_W-1:MULT_HALF_W];

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_BITMAP  = 2'd2,
        MODE_PATTERN = 2'd3
    } mode_t;

    typedef enum logic {
        REG_BRIGHTNESS    = 1'b0,
        REG_BLINK_PATTERN = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic blink;
        logic bitmap;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{blink: 1'b0, bitmap: 1'b1};

    // one scan result moving down the pipeline
    typedef struct packed {
        logic [ROW_W-1:0]  row_drive;
        logic              duty_update;
        logic [COL_W-1:0]  col_mask;
        logic [DUTY_W-1:0] duty_level;
        logic              blink_check;
    } scan_t;

    localparam logic [COL_W-1:0] PRESET_ROM [PRESET_COUNT][ROWS] = '{
        '{15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000},
        '{15'h0400, 15'h0C00, 15'h1FFE, 15'h3FFE, 15'h1FFE, 15'h0C00, 15'h0400},
        '{15'h0010, 15'h0018, 15'h3FFC, 15'h3FFE, 15'h3FFC, 15'h0018, 15'h0010},
        '{15'h0410, 15'h0C18, 15'h1C9C, 15'h3C9E, 15'h1C9C, 15'h0C18, 15'h0410},
        '{15'h05F0, 15'h0908, 15'h1504, 15'h0904, 15'h1504, 15'h0908, 15'h11F0},
        '{15'h01F0, 15'h1D08, 15'h0104, 15'h1D04, 15'h0104, 15'h1D08, 15'h01F0},
        '{15'h09F0, 15'h1D08, 15'h0904, 15'h1D04, 15'h0904, 15'h1D08, 15'h09F0},
        '{15'h03E0, 15'h0410, 15'h09C8, 15'h09C8, 15'h09C8, 15'h0410, 15'h03E0},
        '{15'h1FFC, 15'h2002, 15'h4001, 15'h4001, 15'h41C1, 15'h2632, 15'h180C},
        '{15'h001C, 15'h221E, 15'h143F, 15'h083F, 15'h143F, 15'h221E, 15'h001C},
        '{15'h1F1F, 15'h1111, 15'h1111, 15'h1F1F, 15'h0111, 15'h0111, 15'h011F},
        '{15'h0F0F, 15'h1111, 15'h1111, 15'h0F0F, 15'h1105, 15'h1109, 15'h0F11},
        '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF}
    };

    // 5x7 font for characters 32..125, glyph column k sits in bit k+1
    localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][ROWS] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h08, 8'h08, 8'h08, 8'h08, 8'h00, 8'h08, 8'h00},
        '{8'h14, 8'h14, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h14, 8'h14, 8'h3E, 8'h14, 8'h3E, 8'h14, 8'h14},
        '{8'h08, 8'h3C, 8'h0A, 8'h1C, 8'h28, 8'h1E, 8'h08},
        '{8'h30, 8'h32, 8'h04, 8'h08, 8'h10, 8'h26, 8'h06},
        '{8'h0C, 8'h12, 8'h0A, 8'h04, 8'h2A, 8'h12, 8'h2C},
        '{8'h0C, 8'h08, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h10, 8'h08, 8'h04, 8'h04, 8'h04, 8'h08, 8'h10},
        '{8'h04, 8'h08, 8'h10, 8'h10, 8'h10, 8'h08, 8'h04},
        '{8'h00, 8'h08, 8'h2A, 8'h1C, 8'h2A, 8'h08, 8'h00},
        '{8'h00, 8'h08, 8'h08, 8'h3E, 8'h08, 8'h08, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h18, 8'h10, 8'h08},
        '{8'h00, 8'h00, 8'h00, 8'h3E, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0C, 8'h0C},
        '{8'h00, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01},
        '{8'h1C, 8'h22, 8'h32, 8'h2A, 8'h26, 8'h22, 8'h1C},
        '{8'h08, 8'h0C, 8'h08, 8'h08, 8'h08, 8'h08, 8'h1C},
        '{8'h1C, 8'h22, 8'h20, 8'h10, 8'h08, 8'h04, 8'h3E},
        '{8'h3E, 8'h10, 8'h08, 8'h10, 8'h20, 8'h22, 8'h1C},
        '{8'h10, 8'h18, 8'h14, 8'h12, 8'h3E, 8'h10, 8'h10},
        '{8'h3E, 8'h02, 8'h1E, 8'h20, 8'h20, 8'h22, 8'h1C},
        '{8'h18, 8'h04, 8'h02, 8'h1E, 8'h22, 8'h22, 8'h1C},
        '{8'h3E, 8'h20, 8'h10, 8'h08, 8'h04, 8'h04, 8'h04},
        '{8'h1C, 8'h22, 8'h22, 8'h1C, 8'h22, 8'h22, 8'h1C},
        '{8'h1C, 8'h22, 8'h22, 8'h3C, 8'h20, 8'h10, 8'h0C},
        '{8'h00, 8'h0C, 8'h0C, 8'h00, 8'h0C, 8'h0C, 8'h00},
        '{8'h00, 8'h0C, 8'h0C, 8'h00, 8'h0C, 8'h08, 8'h04},
        '{8'h10, 8'h08, 8'h04, 8'h02, 8'h04, 8'h08, 8'h10},
        '{8'h00, 8'h00, 8'h3E, 8'h00, 8'h3E, 8'h00, 8'h00},
        '{8'h04, 8'h08, 8'h10, 8'h20, 8'h10, 8'h08, 8'h04},
        '{8'h1C, 8'h22, 8'h20, 8'h10, 8'h08, 8'h00, 8'h08},
        '{8'h1C, 8'h22, 8'h20, 8'h2C, 8'h3A, 8'h22, 8'h1C},
        '{8'h08, 8'h14, 8'h22, 8'h22, 8'h3E, 8'h22, 8'h22},
        '{8'h1E, 8'h22, 8'h22, 8'h1E, 8'h22, 8'h22, 8'h1E},
        '{8'h1C, 8'h22, 8'h02, 8'h02, 8'h02, 8'h22, 8'h1C},
        '{8'h0E, 8'h12, 8'h22, 8'h22, 8'h22, 8'h12, 8'h0E},
        '{8'h3E, 8'h02, 8'h02, 8'h1E, 8'h02, 8'h02, 8'h3E},
        '{8'h3E, 8'h02, 8'h02, 8'h1E, 8'h02, 8'h02, 8'h02},
        '{8'h1C, 8'h22, 8'h02, 8'h3A, 8'h22, 8'h22, 8'h3C},
        '{8'h22, 8'h22, 8'h22, 8'h3E, 8'h22, 8'h22, 8'h22},
        '{8'h1C, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h1C},
        '{8'h38, 8'h10, 8'h10, 8'h10, 8'h10, 8'h12, 8'h0C},
        '{8'h22, 8'h12, 8'h0A, 8'h06, 8'h0A, 8'h12, 8'h22},
        '{8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h3E},
        '{8'h22, 8'h36, 8'h2A, 8'h2A, 8'h22, 8'h22, 8'h22},
        '{8'h22, 8'h22, 8'h26, 8'h2A, 8'h32, 8'h22, 8'h22},
        '{8'h1C, 8'h22, 8'h22, 8'h22, 8'h22, 8'h22, 8'h1C},
        '{8'h1E, 8'h22, 8'h22, 8'h1E, 8'h02, 8'h02, 8'h02},
        '{8'h1C, 8'h22, 8'h22, 8'h22, 8'h2A, 8'h12, 8'h2C},
        '{8'h1E, 8'h22, 8'h22, 8'h1E, 8'h0A, 8'h12, 8'h22},
        '{8'h3C, 8'h02, 8'h02, 8'h1C, 8'h20, 8'h20, 8'h1E},
        '{8'h3E, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
        '{8'h22, 8'h22, 8'h22, 8'h22, 8'h22, 8'h22, 8'h1C},
        '{8'h22, 8'h22, 8'h22, 8'h22, 8'h22, 8'h14, 8'h08},
        '{8'h22, 8'h22, 8'h22, 8'h2A, 8'h2A, 8'h2A, 8'h14},
        '{8'h22, 8'h22, 8'h14, 8'h08, 8'h14, 8'h22, 8'h22},
        '{8'h22, 8'h22, 8'h22, 8'h14, 8'h08, 8'h08, 8'h08},
        '{8'h3E, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h3E},
        '{8'h1C, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h1C},
        '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20},
        '{8'h1C, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h1C},
        '{8'h08, 8'h14, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3E},
        '{8'h04, 8'h08, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h20, 8'h30, 8'h28, 8'h24, 8'h28, 8'h30, 8'h20},
        '{8'h00, 8'h00, 8'h08, 8'h08, 8'h08, 8'h00, 8'h00},
        '{8'h02, 8'h06, 8'h0A, 8'h12, 8'h0A, 8'h06, 8'h02},
        '{8'h00, 8'h00, 8'h3C, 8'h04, 8'h3C, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h3E, 8'h00, 8'h3E, 8'h00, 8'h00},
        '{8'h02, 8'h06, 8'h0A, 8'h12, 8'h0A, 8'h06, 8'h02},
        '{8'h20, 8'h30, 8'h28, 8'h24, 8'h28, 8'h30, 8'h20},
        '{8'h00, 8'h00, 8'h3E, 8'h00, 8'h3E, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h1E, 8'h10, 8'h1E, 8'h00, 8'h00},
        '{8'h08, 8'h10, 8'h28, 8'h10, 8'h28, 8'h10, 8'h20},
        '{8'h3C, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h3C},
        '{8'h02, 8'h04, 8'h08, 8'h08, 8'h08, 8'h04, 8'h02},
        '{8'h00, 8'h38, 8'h00, 8'h38, 8'h00, 8'h38, 8'h00},
        '{8'h3C, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h3C},
        '{8'h02, 8'h04, 8'h08, 8'h08, 8'h08, 8'h04, 8'h02},
        '{8'h10, 8'h38, 8'h10, 8'h38, 8'h10, 8'h38, 8'h10},
        '{8'h3C, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h3C},
        '{8'h02, 8'h04, 8'h08, 8'h08, 8'h08, 8'h04, 8'h02},
        '{8'h00, 8'h00, 8'h1C, 8'h02, 8'h1C, 8'h20, 8'h1E},
        '{8'h04, 8'h04, 8'h0E, 8'h04, 8'h04, 8'h24, 8'h18},
        '{8'h00, 8'h00, 8'h22, 8'h22, 8'h22, 8'h32, 8'h2C},
        '{8'h00, 8'h00, 8'h22, 8'h22, 8'h22, 8'h14, 8'h08},
        '{8'h00, 8'h00, 8'h22, 8'h22, 8'h2A, 8'h2A, 8'h14},
        '{8'h00, 8'h00, 8'h22, 8'h14, 8'h08, 8'h14, 8'h22},
        '{8'h00, 8'h22, 8'h22, 8'h22, 8'h3C, 8'h20, 8'h1C},
        '{8'h00, 8'h00, 8'h3E, 8'h10, 8'h08, 8'h04, 8'h3E},
        '{8'h0C, 8'h04, 8'h06, 8'h02, 8'h06, 8'h04, 8'h0C},
        '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
        '{8'h0C, 8'h08, 8'h18, 8'h10, 8'h18, 8'h08, 8'h0C}
    };

    // printable range passes through, anything else shows as a space
    function automatic logic [CHAR_W-1:0] char_clean(input logic [7:0] ch);
        logic [CHAR_W-1:0] res;
        res = CHAR_SPACE;
        if (ch >= CHAR_LOW && ch <= CHAR_HIGH)
        begin
            res = ch[CHAR_W-1:0];
        end
        return res;
    endfunction

    // five lit columns of one character on one row
    function automatic logic [GLYPH_COLS-1:0] glyph_cols(
        input logic [CHAR_W-1:0] ch,
        input logic [RIDX_W-1:0] row
    );
        logic [CHAR_W-1:0] idx;
        logic [7:0]        bits;
        idx  = ch - CHAR_SPACE;
        bits = GLYPH_ROM[idx][row];
        return bits[GLYPH_COLS:1];
    endfunction

endpackage

// File: rtl/led_matrix_row_scanner.sv
// ----------------------------------------------------------------------------
// led_matrix_row_scanner
// Row scan sequencer for a 7x15 multiplexed LED matrix with bitmap, blink and
// 5x7 text modes, double-buffered per frame.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------
//  item     | item_valid / item_stall     | mode, now_ms, char_*, row_select,
//           |                             | row_pixels, pattern_pick
//  result   | result_valid / result_stall | row_drive, duty_update, col_mask,
//           |                             | duty_level
//  config   | psel/penable/pwrite/pready  | paddr, pwdata, prdata
//
// one transaction per cycle in, one per cycle out while not stalled; a sync tick
// gives a result through the registered stages (capture, blink multiply, sum and output)
// load items update the pending buffers and give no result
// the three stages move together; item_stall rises only while a result sits
// in the output register and result_stall is high
// after reset: bitmap mode, all rows blank, phase zero, no clearing pass
//
module led_matrix_row_scanner
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [1:0]                    mode,
    input  logic [31:0]                   now_ms,
    input  logic [7:0]                    char_first,
    input  logic [7:0]                    char_second,
    input  logic [7:0]                    char_third,
    input  logic [2:0]                    row_select,
    input  logic [14:0]                   row_pixels,
    input  logic [7:0]                    pattern_pick,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [6:0]                    row_drive,
    output logic                          duty_update,
    output logic [14:0]                   col_mask,
    output logic [13:0]                   duty_level,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int unsigned ROWS    = lmrs_pkg::ROWS;
    localparam int unsigned SLOTS   = lmrs_pkg::CHAR_SLOTS;
    localparam int unsigned GCOLS   = lmrs_pkg::GLYPH_COLS;
    localparam int unsigned ROW_W   = lmrs_pkg::ROW_W;
    localparam int unsigned COL_W   = lmrs_pkg::COL_W;
    localparam int unsigned PHASE_W = lmrs_pkg::PHASE_W;
    localparam int unsigned RIDX_W  = lmrs_pkg::RIDX_W;
    localparam int unsigned CHAR_W  = lmrs_pkg::CHAR_W;
    localparam int unsigned DUTY_W  = lmrs_pkg::DUTY_W;
    localparam int unsigned PICK_W  = lmrs_pkg::PICK_W;
    localparam int unsigned TIME_W  = lmrs_pkg::TIME_W;
    localparam int unsigned HALF_W  = lmrs_pkg::MULT_HALF_W;
    localparam int unsigned PHALF_W = lmrs_pkg::PROD_HALF_W;
    localparam int unsigned PROD_W  = lmrs_pkg::PROD_W;

    // configuration
    logic [DUTY_W-1:0]       brightness_reg;
    logic [3:0]              blink_pattern_reg;
    logic                    cfg_write;

    // scan and buffer state
    logic [PHASE_W-1:0]      phase_reg,        phase_next;
    logic [ROW_W-1:0]        row_out_reg,      row_out_next;
    logic [CHAR_W-1:0]       pend_chars_reg    [SLOTS];
    logic [CHAR_W-1:0]       pend_chars_next   [SLOTS];
    logic [CHAR_W-1:0]       shown_chars_reg   [SLOTS];
    logic [CHAR_W-1:0]       shown_chars_next  [SLOTS];
    logic [COL_W-1:0]        pend_rows_reg     [ROWS];
    logic [COL_W-1:0]        pend_rows_next    [ROWS];
    logic [COL_W-1:0]        shown_rows_reg    [ROWS];
    logic [COL_W-1:0]        shown_rows_next   [ROWS];
    lmrs_pkg::flags_t        pend_flags_reg,   pend_flags_next;
    lmrs_pkg::flags_t        shown_flags_reg,  shown_flags_next;
    logic [TIME_W-1:0]       pend_start_reg,   pend_start_next;
    logic [TIME_W-1:0]       shown_start_reg,  shown_start_next;

    // pipeline
    logic                    advance;
    logic                    accept;
    logic [7:0]              char_in           [SLOTS];
    lmrs_pkg::scan_t         s1_next;
    logic                    s1_valid_next;
    logic [TIME_W-1:0]       diff_next;
    logic                    s1_valid_reg;
    lmrs_pkg::scan_t         s1_reg;
    logic [TIME_W-1:0]       s1_diff_reg;
    logic                    s2_valid_reg;
    lmrs_pkg::scan_t         s2_reg;
    logic [PHALF_W-1:0]      s2_prod_lo_reg;
    logic [PHALF_W-1:0]      s2_prod_hi_reg;
    logic [PROD_W-1:0]       prod_sum;
    logic                    period_odd;
    logic                    result_valid_reg;
    logic [ROW_W-1:0]        row_drive_reg;
    logic                    duty_update_reg;
    logic [COL_W-1:0]        col_mask_reg;
    logic [DUTY_W-1:0]       duty_level_reg;

    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = !advance;
    assign accept     = item_valid && advance;

    assign char_in[0] = char_first;
    assign char_in[1] = char_second;
    assign char_in[2] = char_third;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg    <= lmrs_pkg::BRIGHTNESS_RESET;
            blink_pattern_reg <= lmrs_pkg::BLINK_PATTERN_RESET;
        end
        else if (cfg_write)
        begin
            case (lmrs_pkg::reg_index_t'(paddr[2]))
                lmrs_pkg::REG_BRIGHTNESS:    brightness_reg    <= pwdata[DUTY_W-1:0];
                lmrs_pkg::REG_BLINK_PATTERN: blink_pattern_reg <= pwdata[3:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        case (lmrs_pkg::reg_index_t'(paddr[2]))
            lmrs_pkg::REG_BRIGHTNESS:    prdata = {{(32-DUTY_W){1'b0}}, brightness_reg};
            lmrs_pkg::REG_BLINK_PATTERN: prdata = {28'd0, blink_pattern_reg};
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // item decode, buffer updates and scan step
    // ------------------------------------------------------------------------
    always_comb
    begin
        logic                    ended;
        logic [PICK_W-1:0]       pick;
        logic [RIDX_W-1:0]       row;
        logic [RIDX_W-1:0]       prev;
        logic [COL_W-1:0]        glyph_mask;

        phase_next       = phase_reg;
        row_out_next     = row_out_reg;
        pend_chars_next  = pend_chars_reg;
        shown_chars_next = shown_chars_reg;
        pend_rows_next   = pend_rows_reg;
        shown_rows_next  = shown_rows_reg;
        pend_flags_next  = pend_flags_reg;
        shown_flags_next = shown_flags_reg;
        pend_start_next  = pend_start_reg;
        shown_start_next = shown_start_reg;
        s1_valid_next    = 1'b0;
        s1_next          = '0;
        diff_next        = now_ms - shown_start_reg;
        ended            = 1'b0;
        pick             = '0;

        row  = phase_reg[PHASE_W-1:1];
        prev = (row == '0) ? RIDX_W'(ROWS - 1) : row - 1'b1;
        for (int s = 0; s < SLOTS; s++)
        begin
            glyph_mask[s*GCOLS +: GCOLS] = lmrs_pkg::glyph_cols(shown_chars_reg[s], row);
        end

        if (accept)
        begin
            case (lmrs_pkg::mode_t'(mode))
                lmrs_pkg::MODE_STRING:
                begin
                    // a zero ends the string, blanking it and every later slot
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (char_in[s] == 8'd0)
                        begin
                            ended = 1'b1;
                        end
                        pend_chars_next[s] = ended ? lmrs_pkg::CHAR_SPACE
                                                   : lmrs_pkg::char_clean(char_in[s]);
                    end
                    pend_flags_next = '{blink: 1'b0, bitmap: 1'b0};
                    pend_start_next = '0;
                end
                lmrs_pkg::MODE_BITMAP:
                begin
                    if (row_select < RIDX_W'(ROWS))
                    begin
                        pend_rows_next[row_select] = row_pixels;
                        pend_flags_next = '{blink: 1'b0, bitmap: 1'b1};
                        pend_start_next = '0;
                    end
                end
                lmrs_pkg::MODE_PATTERN:
                begin
                    if (pattern_pick < 8'(lmrs_pkg::PRESET_COUNT))
                    begin
                        pick = pattern_pick[PICK_W-1:0];
                    end
                    for (int r = 0; r < ROWS; r++)
                    begin
                        pend_rows_next[r] = lmrs_pkg::PRESET_ROM[pick][r];
                    end
                    if (pick == blink_pattern_reg)
                    begin
                        pend_flags_next = '{blink: 1'b1, bitmap: 1'b1};
                        pend_start_next = now_ms;
                    end
                    else
                    begin
                        pend_flags_next = '{blink: 1'b0, bitmap: 1'b1};
                        pend_start_next = '0;
                    end
                end
                lmrs_pkg::MODE_TICK:
                begin
                    s1_valid_next = 1'b1;
                    if (!phase_reg[0])
                    begin
                        row_out_next         = row_out_reg & ~(ROW_W'(1) << prev);
                        s1_next.duty_update  = 1'b1;
                        s1_next.col_mask     = shown_flags_reg.bitmap ? shown_rows_reg[row]
                                                                      : glyph_mask;
                        s1_next.duty_level   = (brightness_reg > lmrs_pkg::DUTY_MAX)
                                               ? lmrs_pkg::DUTY_MAX : brightness_reg;
                        s1_next.blink_check  = shown_flags_reg.bitmap && shown_flags_reg.blink;
                    end
                    else
                    begin
                        row_out_next = row_out_reg | (ROW_W'(1) << row);
                    end
                    s1_next.row_drive = row_out_next;

                    // frame end: pending buffers become visible
                    if (phase_reg == PHASE_W'(lmrs_pkg::PHASES - 1))
                    begin
                        phase_next       = '0;
                        shown_chars_next = pend_chars_reg;
                        shown_rows_next  = pend_rows_reg;
                        shown_flags_next = pend_flags_reg;
                        shown_start_next = pend_start_reg;
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= '0;
            row_out_reg     <= '0;
            pend_flags_reg  <= lmrs_pkg::FLAGS_RESET;
            shown_flags_reg <= lmrs_pkg::FLAGS_RESET;
            pend_start_reg  <= '0;
            shown_start_reg <= '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                pend_chars_reg[s]  <= lmrs_pkg::CHAR_SPACE;
                shown_chars_reg[s] <= lmrs_pkg::CHAR_SPACE;
            end
            for (int r = 0; r < ROWS; r++)
            begin
                pend_rows_reg[r]  <= '0;
                shown_rows_reg[r] <= '0;
            end
        end
        else
        begin
            phase_reg       <= phase_next;
            row_out_reg     <= row_out_next;
            pend_chars_reg  <= pend_chars_next;
            shown_chars_reg <= shown_chars_next;
            pend_rows_reg   <= pend_rows_next;
            shown_rows_reg  <= shown_rows_next;
            pend_flags_reg  <= pend_flags_next;
            shown_flags_reg <= shown_flags_next;
            pend_start_reg  <= pend_start_next;
            shown_start_reg <= shown_start_next;
        end
    end

    // ------------------------------------------------------------------------
    // result pipeline: elapsed time / period via reciprocal, split multiply
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg     <= accept && s1_valid_next;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg         <= s1_next;
            s1_diff_reg    <= diff_next;
            s2_reg         <= s1_reg;
            s2_prod_lo_reg <= PHALF_W'(s1_diff_reg) * PHALF_W'(lmrs_pkg::DIV_MULT_LO);
            s2_prod_hi_reg <= PHALF_W'(s1_diff_reg) * PHALF_W'(lmrs_pkg::DIV_MULT_HI);
        end
    end

    assign prod_sum   = PROD_W'(s2_prod_lo_reg) + (PROD_W'(s2_prod_hi_reg) << HALF_W);
    assign period_odd = prod_sum[lmrs_pkg::DIV_SHIFT];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            row_drive_reg   <= s2_reg.row_drive;
            duty_update_reg <= s2_reg.duty_update;
            col_mask_reg    <= (s2_reg.blink_check && period_odd) ? '0 : s2_reg.col_mask;
            duty_level_reg  <= s2_reg.duty_level;
        end
    end

    assign result_valid = result_valid_reg;
    assign row_drive    = row_drive_reg;
    assign duty_update  = duty_update_reg;
    assign col_mask     = col_mask_reg;
    assign duty_level   = duty_level_reg;

endmodule
